### hdl/nested_scope_time_profiler_assert.svh
// assertion macros for the nested scope time profiler
`ifndef NESTED_SCOPE_TIME_PROFILER_ASSERT_SVH
`define NESTED_SCOPE_TIME_PROFILER_ASSERT_SVH
`ifndef SYNTHESIS
`define NSTP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NSTP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NSTP_ASSERT(label, clk, rst_n, prop, msg)
`define NSTP_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hdl/nstp_pkg.sv
// shared types, codes and constants of the nested scope time profiler
`timescale 1ns / 1ps
package nstp_pkg;

    localparam int NUM_COMPONENTS_DEF = 10;
    localparam int STACK_DEPTH_DEF    = 64;
    localparam int COMP_W             = 4;
    localparam int DATA_W             = 64;

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_BEGIN = 3'd1,
        MODE_END   = 3'd2,
        MODE_HASH  = 3'd3,
        MODE_STOP  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CLOCK     = 3'd1,
        ERR_COMPONENT = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_MISMATCH  = 3'd4,
        ERR_UNCLOSED  = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_REPORT  = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [COMP_W-1:0] component;
        logic [DATA_W-1:0] timestamp_ns;
        logic              clock_fail;
        logic [DATA_W-1:0] hash_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        record_kind;
        logic              status;
        logic [2:0]        fault_code;
        logic [COMP_W-1:0] component_index;
        logic [DATA_W-1:0] call_count;
        logic [DATA_W-1:0] elapsed_total_ns;
        logic [DATA_W-1:0] hash_total;
        logic              last;
    } rec_t;

    // control of one counter memory
    typedef struct packed {
        logic              clr;
        logic              we;
        logic [COMP_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [COMP_W-1:0] raddr;
    } stat_ctl_t;

    // first error sticks
    function automatic logic [2:0] note_err(input logic [2:0] cur, input logic [2:0] code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

### hdl/nstp_intf.sv
// request and record channel interfaces
`timescale 1ns / 1ps
interface nstp_cmd_if;
    import nstp_pkg::*;
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nstp_rpt_if;
    import nstp_pkg::*;
    logic valid;
    logic ready;
    rec_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/nstp_stat_ram.sv
// per-component counter memory with entry valid bits, cleared at once
`timescale 1ns / 1ps
module nstp_stat_ram #(
    parameter int NUM_COMPONENTS = nstp_pkg::NUM_COMPONENTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nstp_pkg::stat_ctl_t       ctl,
    output logic [nstp_pkg::DATA_W-1:0] rdata
);
    import nstp_pkg::*;

    localparam int IDX_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

    logic [DATA_W-1:0]         mem [NUM_COMPONENTS];
    logic [NUM_COMPONENTS-1:0] vld_reg;
    logic [NUM_COMPONENTS-1:0] vld_next;
    logic                      rvld_reg;
    logic [DATA_W-1:0]         rdata_reg;
    logic [IDX_W-1:0]          waddr;
    logic [IDX_W-1:0]          raddr;

    assign waddr = ctl.waddr[IDX_W-1:0];
    assign raddr = ctl.raddr[IDX_W-1:0];

    always_comb
    begin
        vld_next = vld_reg;
        if (ctl.clr)
        begin
            vld_next = '0;
        end
        else if (ctl.we)
        begin
            vld_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (ctl.re)
            begin
                rvld_reg <= vld_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= ctl.wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // an entry never written since start reads as zero
    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

### hdl/nested_scope_time_profiler.sv
// nested scope time profiler: scope stack and per-component call, time and hash counters
// begin, end, hash: decode, stack read, then counter read-modify-write; result loaded in S_RESP, then idle again
// the longest path is a stack read then a counter read-modify-write through registered-read memories
// start, unused modes and no-op requests: result loaded in S_RESP straight after S_DECODE
// stop: each component report is a memory read then a load, then one summary record
// reset clears control state and counter valid bits at once; no clearing pass is needed
`timescale 1ns / 1ps
`include "nested_scope_time_profiler_assert.svh"
module nested_scope_time_profiler #(
    parameter int NUM_COMPONENTS = nstp_pkg::NUM_COMPONENTS_DEF,
    parameter int STACK_DEPTH    = nstp_pkg::STACK_DEPTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    nstp_cmd_if.sink   cmd,
    nstp_rpt_if.source rpt
);
    import nstp_pkg::*;

    localparam int IDX_W   = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int SP_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    localparam logic [COMP_W:0]      COMP_LIM  = (COMP_W + 1)'(NUM_COMPONENTS);
    localparam logic [DEPTH_W-1:0]   DEPTH_LIM = DEPTH_W'(STACK_DEPTH);
    localparam logic [IDX_W-1:0]     IDX_LAST  = IDX_W'(NUM_COMPONENTS - 1);

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_STEP2   = 8'b0000_0100,
        S_STEP3   = 8'b0000_1000,
        S_RESP    = 8'b0001_0000,
        S_REP_RD  = 8'b0010_0000,
        S_REP_OUT = 8'b0100_0000,
        S_SUM     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // request being worked on
    cmd_t              cmd_reg, cmd_next;

    // profiler state
    logic              collecting_reg, collecting_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DATA_W-1:0] unscoped_reg, unscoped_next;
    logic [2:0]        sticky_reg, sticky_next;

    // working registers
    logic [DATA_W-1:0] diff_reg, diff_next;
    logic [COMP_W-1:0] tgt_reg, tgt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              status_reg, status_next;

    // record output register
    logic              rpt_valid_reg, rpt_valid_next;
    rec_t              rpt_data_reg, rpt_data_next;
    logic              out_free;

    // scope stack memory, component and resume time per frame
    logic [COMP_W-1:0] fcomp_mem [STACK_DEPTH];
    logic [DATA_W-1:0] ftime_mem [STACK_DEPTH];
    logic [COMP_W-1:0] fcomp_rd_reg;
    logic [DATA_W-1:0] ftime_rd_reg;
    logic              stk_re;
    logic [SP_W-1:0]   stk_raddr;
    logic              fcomp_we;
    logic              ftime_we;
    logic [SP_W-1:0]   stk_waddr;
    logic [COMP_W-1:0] stk_wcomp;
    logic [DATA_W-1:0] stk_wtime;

    // counter memories
    stat_ctl_t         calls_ctl, elap_ctl, hash_ctl;
    logic [DATA_W-1:0] calls_rd, elap_rd, hash_rd;
    logic              stat_clr;

    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic               comp_ok;
    logic               fcomp_ok;
    logic               depth_full;

    // terms for the checks
    logic               cmd_fire;
    logic               sticky_held;

    assign depth_m1   = depth_reg - DEPTH_W'(1);
    assign depth_m2   = depth_reg - DEPTH_W'(2);
    assign comp_ok    = {1'b0, cmd_reg.component} < COMP_LIM;
    assign fcomp_ok   = {1'b0, fcomp_rd_reg} < COMP_LIM;
    assign depth_full = depth_reg >= DEPTH_LIM;

    assign cmd.ready = (state_reg == S_IDLE);
    assign rpt.valid = rpt_valid_reg;
    assign rpt.data  = rpt_data_reg;
    assign out_free  = !rpt_valid_reg || rpt.ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        collecting_next = collecting_reg;
        depth_next      = depth_reg;
        unscoped_next   = unscoped_reg;
        sticky_next     = sticky_reg;
        diff_next       = diff_reg;
        tgt_next        = tgt_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        rpt_valid_next  = rpt_valid_reg && !rpt.ready;
        rpt_data_next   = rpt_data_reg;

        stk_re    = 1'b0;
        stk_raddr = depth_m1[SP_W-1:0];
        fcomp_we  = 1'b0;
        ftime_we  = 1'b0;
        stk_waddr = depth_reg[SP_W-1:0];
        stk_wcomp = cmd_reg.component;
        stk_wtime = cmd_reg.timestamp_ns;

        stat_clr  = 1'b0;
        calls_ctl = '0;
        elap_ctl  = '0;
        hash_ctl  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd.data;
                    state_next = S_DECODE;
                end
            end

            // checks on registered state; launch the stack read and, for begin, the call count read
            S_DECODE:
            begin
                status_next = 1'b0;
                state_next  = S_RESP;
                unique case (cmd_reg.mode)
                    MODE_START:
                    begin
                        stat_clr        = 1'b1;
                        depth_next      = '0;
                        unscoped_next   = '0;
                        sticky_next     = ERR_NONE;
                        collecting_next = 1'b1;
                    end
                    MODE_BEGIN:
                    begin
                        if (collecting_reg)
                        begin
                            priority if (!comp_ok)
                            begin
                                sticky_next = note_err(sticky_reg, ERR_COMPONENT);
                                status_next = 1'b1;
                            end
                            else if (depth_full)
                            begin
                                sticky_next = note_err(sticky_reg, ERR_OVERFLOW);
                                status_next = 1'b1;
                            end
                            else if (cmd_reg.clock_fail)
                            begin
                                sticky_next = note_err(sticky_reg, ERR_CLOCK);
                                status_next = 1'b1;
                            end
                            else
                            begin
                                // parent frame and the new component's call count
                                stk_re          = (depth_reg != '0);
                                calls_ctl.re    = 1'b1;
                                calls_ctl.raddr = cmd_reg.component;
                                state_next      = S_STEP2;
                            end
                        end
                    end
                    MODE_END:
                    begin
                        if (collecting_reg)
                        begin
                            priority if (!comp_ok || depth_reg == '0)
                            begin
                                sticky_next = note_err(sticky_reg, ERR_MISMATCH);
                                status_next = 1'b1;
                            end
                            else
                            begin
                                stk_re     = 1'b1;
                                state_next = S_STEP2;
                            end
                        end
                    end
                    MODE_HASH:
                    begin
                        if (collecting_reg && cmd_reg.hash_count != '0)
                        begin
                            priority if (depth_reg == '0)
                            begin
                                unscoped_next = unscoped_reg + cmd_reg.hash_count;
                            end
                            else
                            begin
                                stk_re     = 1'b1;
                                state_next = S_STEP2;
                            end
                        end
                    end
                    MODE_STOP:
                    begin
                        if (depth_reg != '0)
                        begin
                            sticky_next = note_err(sticky_reg, ERR_UNCLOSED);
                        end
                        idx_next   = '0;
                        state_next = S_REP_RD;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // stack frame is out; time since resume and the second read
            S_STEP2:
            begin
                diff_next  = cmd_reg.timestamp_ns - ftime_rd_reg;
                state_next = S_RESP;
                unique case (cmd_reg.mode)
                    MODE_BEGIN:
                    begin
                        calls_ctl.we    = 1'b1;
                        calls_ctl.waddr = cmd_reg.component;
                        calls_ctl.wdata = calls_rd + DATA_W'(1);
                        fcomp_we        = 1'b1;
                        ftime_we        = 1'b1;
                        depth_next      = depth_reg + DEPTH_W'(1);
                        // charge the parent
                        if (depth_reg != '0 && fcomp_ok)
                        begin
                            elap_ctl.re    = 1'b1;
                            elap_ctl.raddr = fcomp_rd_reg;
                            tgt_next       = fcomp_rd_reg;
                            state_next     = S_STEP3;
                        end
                    end
                    MODE_END:
                    begin
                        priority if (fcomp_rd_reg != cmd_reg.component)
                        begin
                            sticky_next = note_err(sticky_reg, ERR_MISMATCH);
                            status_next = 1'b1;
                        end
                        else if (cmd_reg.clock_fail)
                        begin
                            sticky_next = note_err(sticky_reg, ERR_CLOCK);
                            status_next = 1'b1;
                        end
                        else
                        begin
                            elap_ctl.re    = 1'b1;
                            elap_ctl.raddr = cmd_reg.component;
                            tgt_next       = cmd_reg.component;
                            state_next     = S_STEP3;
                        end
                    end
                    MODE_HASH:
                    begin
                        if (fcomp_ok)
                        begin
                            hash_ctl.re    = 1'b1;
                            hash_ctl.raddr = fcomp_rd_reg;
                            tgt_next       = fcomp_rd_reg;
                            state_next     = S_STEP3;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // counter write-back
            S_STEP3:
            begin
                state_next = S_RESP;
                unique case (cmd_reg.mode)
                    MODE_BEGIN:
                    begin
                        elap_ctl.we    = 1'b1;
                        elap_ctl.waddr = tgt_reg;
                        elap_ctl.wdata = elap_rd + diff_reg;
                    end
                    MODE_END:
                    begin
                        elap_ctl.we    = 1'b1;
                        elap_ctl.waddr = tgt_reg;
                        elap_ctl.wdata = elap_rd + diff_reg;
                        depth_next     = depth_m1;
                        // resume the parent
                        if (depth_reg > DEPTH_W'(1))
                        begin
                            ftime_we  = 1'b1;
                            stk_waddr = depth_m2[SP_W-1:0];
                        end
                    end
                    MODE_HASH:
                    begin
                        hash_ctl.we    = 1'b1;
                        hash_ctl.waddr = tgt_reg;
                        hash_ctl.wdata = hash_rd + cmd_reg.hash_count;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rpt_valid_next = 1'b1;
                    rpt_data_next  = '0;
                    rpt_data_next.record_kind = KIND_STATUS;
                    rpt_data_next.status      = status_reg;
                    rpt_data_next.fault_code  = sticky_reg;
                    rpt_data_next.last        = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_REP_RD:
            begin
                calls_ctl.re    = 1'b1;
                calls_ctl.raddr = COMP_W'(idx_reg);
                elap_ctl.re     = 1'b1;
                elap_ctl.raddr  = COMP_W'(idx_reg);
                hash_ctl.re     = 1'b1;
                hash_ctl.raddr  = COMP_W'(idx_reg);
                state_next      = S_REP_OUT;
            end

            S_REP_OUT:
            begin
                if (out_free)
                begin
                    rpt_valid_next = 1'b1;
                    rpt_data_next  = '0;
                    rpt_data_next.record_kind      = KIND_REPORT;
                    rpt_data_next.component_index  = COMP_W'(idx_reg);
                    rpt_data_next.call_count       = calls_rd;
                    rpt_data_next.elapsed_total_ns = elap_rd;
                    rpt_data_next.hash_total       = hash_rd;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_REP_RD;
                    end
                end
            end

            S_SUM:
            begin
                if (out_free)
                begin
                    rpt_valid_next = 1'b1;
                    rpt_data_next  = '0;
                    rpt_data_next.record_kind = KIND_SUMMARY;
                    rpt_data_next.status      = (sticky_reg != ERR_NONE);
                    rpt_data_next.fault_code  = sticky_reg;
                    rpt_data_next.hash_total  = unscoped_reg;
                    rpt_data_next.last        = 1'b1;
                    collecting_next = 1'b0;
                    depth_next      = '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        calls_ctl.clr = stat_clr;
        elap_ctl.clr  = stat_clr;
        hash_ctl.clr  = stat_clr;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            collecting_reg <= 1'b0;
            depth_reg      <= '0;
            unscoped_reg   <= '0;
            sticky_reg     <= ERR_NONE;
            idx_reg        <= '0;
            rpt_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            collecting_reg <= collecting_next;
            depth_reg      <= depth_next;
            unscoped_reg   <= unscoped_next;
            sticky_reg     <= sticky_next;
            idx_reg        <= idx_next;
            rpt_valid_reg  <= rpt_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        diff_reg     <= diff_next;
        tgt_reg      <= tgt_next;
        status_reg   <= status_next;
        rpt_data_reg <= rpt_data_next;
    end

    // scope stack memory
    always_ff @(posedge clk)
    begin
        if (fcomp_we)
        begin
            fcomp_mem[stk_waddr] <= stk_wcomp;
        end
        if (ftime_we)
        begin
            ftime_mem[stk_waddr] <= stk_wtime;
        end
        if (stk_re)
        begin
            fcomp_rd_reg <= fcomp_mem[stk_raddr];
            ftime_rd_reg <= ftime_mem[stk_raddr];
        end
    end

    nstp_stat_ram #(
        .NUM_COMPONENTS (NUM_COMPONENTS)
    ) u_calls (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (calls_ctl),
        .rdata (calls_rd)
    );

    nstp_stat_ram #(
        .NUM_COMPONENTS (NUM_COMPONENTS)
    ) u_elapsed (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (elap_ctl),
        .rdata (elap_rd)
    );

    nstp_stat_ram #(
        .NUM_COMPONENTS (NUM_COMPONENTS)
    ) u_hashes (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (hash_ctl),
        .rdata (hash_rd)
    );

    // checks
    // a held error may only change while a request is decoded
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign sticky_held = (sticky_reg != ERR_NONE) && (state_reg != S_DECODE);

    `NSTP_ASSERT_NEVER(a_depth_bound, clk, rst_n, depth_reg > DEPTH_LIM, "stack depth past limit")
    `NSTP_ASSERT(a_idle_empty, clk, rst_n, !collecting_reg |-> depth_reg == '0, "open scopes")
    `NSTP_ASSERT(a_sticky_hold, clk, rst_n, sticky_held |=> $stable(sticky_reg), "error changed")
    `NSTP_ASSERT(a_accept_decode, clk, rst_n, cmd_fire |=> state_reg == S_DECODE, "lost request")

endmodule
